// ----- hw/rtl/per_source_connection_limiter_top_defines.svh -----
// Assertion helpers used by the checker of the limiter.
`ifndef PER_SOURCE_CONNECTION_LIMITER_TOP_DEFINES_SVH
`define PER_SOURCE_CONNECTION_LIMITER_TOP_DEFINES_SVH

// Same-cycle implication.
`define PSCL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PSCL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pscl_pkg.sv -----
package pscl_pkg;

    localparam int ENTRIES    = 64;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] KIND_CHECK = 2'd0;
    localparam logic [1:0] KIND_CONN  = 2'd1;
    localparam logic [1:0] KIND_AUTH  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CONN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AUTH_FAIL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAN_DURATION   = 3'd4;

    localparam logic [31:0] RST_RESET_INTERVAL = 32'd1000;
    localparam logic [15:0] RST_MAX_CONN       = 16'd10;
    localparam logic [15:0] RST_MAX_AUTH_FAIL  = 16'd5;
    localparam logic [30:0] RST_BAN_DURATION   = 31'd300000;

    typedef struct packed {
        logic [31:0] key;
        logic [15:0] conn;
        logic [15:0] fail;
        logic [31:0] last;
        logic [31:0] ban;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic miss_done;
        logic out_free;
    } t_sts;

endpackage

// ----- hw/rtl/pscl_ctrl.sv -----
module pscl_ctrl import pscl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd.load     = i_in_valid && o_in_ready;
        o_cmd.scan     = (r_state == ST_SCAN);
        o_cmd.exec     = (r_state == ST_EXEC);
        o_cmd.out_load = (r_state == ST_DONE) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.hit || i_sts.miss_done) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/pscl_dp.sv -----
module pscl_dp import pscl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [1:0]            i_kind,
    input  logic [31:0]           i_source_address,
    input  logic [31:0]           i_now_tick,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_allowed,
    output logic                  o_entry_found,
    output logic                  o_table_full
);

    // configuration
    logic        r_enable;
    logic [31:0] r_interval;
    logic [15:0] r_max_conn;
    logic [15:0] r_max_fail;
    logic [30:0] r_ban_dur;

    // request
    logic [1:0]  r_kind;
    logic [31:0] r_addr;
    logic [31:0] r_now;

    // search
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_fill;
    logic [IDX_W-1:0] r_pidx;
    logic             r_pend;
    logic             r_found;

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    logic             issue_ok;
    logic             hit;
    logic             rd_en;

    // update
    t_entry           cur;
    t_entry           wdata;
    logic             we;
    logic             ins;
    logic             res_allowed;
    logic             res_full;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      ban_diff;
    logic [31:0]      el_diff;
    logic             banned;
    logic             expired;
    logic             table_full;
    logic [15:0]      conn_inc;
    logic [15:0]      fail_inc;
    logic [31:0]      ban_new;

    logic r_res_allowed;
    logic r_res_found;
    logic r_res_full;
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_interval <= RST_RESET_INTERVAL;
            r_max_conn <= RST_MAX_CONN;
            r_max_fail <= RST_MAX_AUTH_FAIL;
            r_ban_dur  <= RST_BAN_DURATION;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ENABLE:         r_enable   <= i_cfg_wdata[0];
                REG_RESET_INTERVAL: r_interval <= i_cfg_wdata[31:0];
                REG_MAX_CONN:       r_max_conn <= i_cfg_wdata[15:0];
                REG_MAX_AUTH_FAIL:  r_max_fail <= i_cfg_wdata[15:0];
                REG_BAN_DURATION:   r_ban_dur  <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_addr <= i_source_address;
            r_now  <= i_now_tick;
        end
    end

    // one entry read per cycle; compare works on the registered read data
    assign issue_ok = (r_idx < r_fill);
    assign hit      = r_pend && (r_rdata.key == r_addr);
    assign rd_en    = i_cmd.scan && issue_ok && !hit;

    assign o_sts.hit       = hit;
    assign o_sts.miss_done = !issue_ok && !hit;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= rd_en;
                if (rd_en) r_idx <= CNT_W'(r_idx + 1'b1);
                if (hit) r_found <= 1'b1;
            end
            if (i_cmd.exec && we && ins) r_fill <= CNT_W'(r_fill + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_pidx  <= r_idx[IDX_W-1:0];
            r_rdata <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we) r_mem[waddr] <= wdata;
    end

    always_comb begin
        if (r_found) begin
            cur = r_rdata;
        end else begin
            cur.key  = r_addr;
            cur.conn = '0;
            cur.fail = '0;
            cur.last = r_now;
            cur.ban  = r_now;
        end
    end

    // times compared by signed difference
    assign ban_diff   = cur.ban - r_now;
    assign el_diff    = r_now - cur.last;
    assign banned     = (ban_diff != '0) && !ban_diff[31];
    assign expired    = !el_diff[31] && (el_diff > r_interval);
    assign table_full = !r_found && (r_fill >= CNT_W'(ENTRIES));
    assign conn_inc   = (cur.conn == 16'hFFFF) ? cur.conn : 16'(cur.conn + 1'b1);
    assign fail_inc   = (cur.fail == 16'hFFFF) ? cur.fail : 16'(cur.fail + 1'b1);
    assign ban_new    = r_now + {1'b0, r_ban_dur};
    assign waddr      = r_found ? r_pidx : r_fill[IDX_W-1:0];

    always_comb begin
        wdata       = cur;
        we          = 1'b0;
        ins         = 1'b0;
        res_allowed = 1'b0;
        res_full    = 1'b0;
        case (r_kind)
            KIND_CHECK: begin
                if (!r_enable || !r_found) begin
                    res_allowed = 1'b1;
                end else if (banned) begin
                    res_allowed = 1'b0;
                end else if (expired) begin
                    res_allowed = 1'b1;
                    wdata.conn  = '0;
                    wdata.last  = r_now;
                    we          = 1'b1;
                end else begin
                    res_allowed = (cur.conn < r_max_conn);
                end
            end
            KIND_CONN, KIND_AUTH: begin
                if (r_enable) begin
                    if (table_full) begin
                        res_full = 1'b1;
                    end else begin
                        we  = 1'b1;
                        ins = !r_found;
                        if (r_kind == KIND_CONN) begin
                            wdata.conn = conn_inc;
                            wdata.last = r_now;
                        end else begin
                            wdata.fail = fail_inc;
                            if (fail_inc >= r_max_fail) wdata.ban = ban_new;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_allowed <= res_allowed;
            r_res_found   <= r_found;
            r_res_full    <= res_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_allowed     <= r_res_allowed;
            o_entry_found <= r_res_found;
            o_table_full  <= r_res_full;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/per_source_connection_limiter_top.sv -----
// Channel  Handshake                 Payload
// in       i_in_valid / o_in_ready   i_kind, i_source_address, i_now_tick
// out      o_out_valid / i_out_ready o_allowed, o_entry_found, o_table_full
// cfg      i_cfg_wr_en               i_cfg_index, i_cfg_wdata
//
// One request at a time; the search reads the entry memory one entry a cycle and
// stops on a hit or once all the entries in use are read.
// Synchronous active-low reset; table empty via fill count, no clearing pass.
// A finished result waits in the output register while the next request is taken.
module per_source_connection_limiter_top import pscl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_kind,
    input  logic [31:0]           i_source_address,
    input  logic [31:0]           i_now_tick,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_allowed,
    output logic                  o_entry_found,
    output logic                  o_table_full,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    pscl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pscl_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_kind           (i_kind),
        .i_source_address (i_source_address),
        .i_now_tick       (i_now_tick),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_allowed        (o_allowed),
        .o_entry_found    (o_entry_found),
        .o_table_full     (o_table_full)
    );

endmodule

// ----- hw/rtl/pscl_chk.sv -----
`include "per_source_connection_limiter_top_defines.svh"

module pscl_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_allowed,
    input logic o_entry_found,
    input logic o_table_full
);

    `PSCL_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result lost under stall")
    `PSCL_ASSERT_NXT(a_one_req, i_in_valid && o_in_ready, !o_in_ready, "second request taken early")
    `PSCL_ASSERT_NXT(a_no_early, i_in_valid && o_in_ready && !o_out_valid, !o_out_valid, "result too early")
    `PSCL_ASSERT_IMP(a_full_excl, o_out_valid && o_table_full, !o_entry_found && !o_allowed, "bad full result")

endmodule

bind per_source_connection_limiter_top pscl_chk u_chk (.*);
